/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GDOC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("gdoc assertion failed");

// next-cycle implication
`define GDOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("gdoc assertion failed");

`endif

/* src/gdoc_pkg.sv */
// ----------------------------------------------------------------------------
// gdoc_pkg
// constants, month table and control store for the date offset calculator
// ----------------------------------------------------------------------------
`default_nettype none

package gdoc_pkg;

	localparam int unsigned GDOC_YEAR_LIMIT = 9999;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int OFF_W    = 23;
	localparam int DOY_W    = 9;
	localparam int WD_W     = 3;
	localparam int SERIAL_W = 22;
	localparam int ACC_W    = 23;
	localparam int TOT_W    = 25;

	localparam logic [YEAR_W-1:0]   BASE_YEAR  = 14'd1900;
	localparam logic [SERIAL_W-1:0] SERIAL_MAX = 22'h3FFFFF;
	localparam logic [8:0]          BASE_C400  = 9'd300;

	// branch conditions
	localparam logic [3:0] C_NEVER      = 4'd0;
	localparam logic [3:0] C_ALWAYS     = 4'd1;
	localparam logic [3:0] C_IN_VALID   = 4'd2;
	localparam logic [3:0] C_HEAD_BAD   = 4'd3;
	localparam logic [3:0] C_CY_LT_Y    = 4'd4;
	localparam logic [3:0] C_DAY_BAD    = 4'd5;
	localparam logic [3:0] C_MC_LT_M    = 4'd6;
	localparam logic [3:0] C_TOT_LT1    = 4'd7;
	localparam logic [3:0] C_TOT_LE_ACC = 4'd8;
	localparam logic [3:0] C_FWD        = 4'd9;
	localparam logic [3:0] C_CY_GT_LIM  = 4'd10;
	localparam logic [3:0] C_RES_MSTEP  = 4'd11;
	localparam logic [3:0] C_OUT_FREE   = 4'd12;

	// datapath operations
	localparam logic [3:0] OP_NOP       = 4'd0;
	localparam logic [3:0] OP_LOAD      = 4'd1;
	localparam logic [3:0] OP_YEAR_UP   = 4'd2;
	localparam logic [3:0] OP_YEAR_DN   = 4'd3;
	localparam logic [3:0] OP_DOY_ADD   = 4'd4;
	localparam logic [3:0] OP_DOY_FIN   = 4'd5;
	localparam logic [3:0] OP_SUM       = 4'd6;
	localparam logic [3:0] OP_TOT       = 4'd7;
	localparam logic [3:0] OP_REM       = 4'd8;
	localparam logic [3:0] OP_RES_SUB   = 4'd9;
	localparam logic [3:0] OP_EMIT_RES  = 4'd10;
	localparam logic [3:0] OP_EMIT_SRC  = 4'd11;
	localparam logic [3:0] OP_EMIT_ZERO = 4'd12;

	// program steps
	localparam logic [3:0] S_FETCH     = 4'd0;
	localparam logic [3:0] S_CHECK     = 4'd1;
	localparam logic [3:0] S_YWALK     = 4'd2;
	localparam logic [3:0] S_DCHK      = 4'd3;
	localparam logic [3:0] S_MWALK     = 4'd4;
	localparam logic [3:0] S_SUM       = 4'd5;
	localparam logic [3:0] S_TOT       = 4'd6;
	localparam logic [3:0] S_TCHK      = 4'd7;
	localparam logic [3:0] S_BACK      = 4'd8;
	localparam logic [3:0] S_FWD       = 4'd9;
	localparam logic [3:0] S_LCHK      = 4'd10;
	localparam logic [3:0] S_RMWALK    = 4'd11;
	localparam logic [3:0] S_EMIT_RES  = 4'd12;
	localparam logic [3:0] S_EMIT_SRC  = 4'd14;
	localparam logic [3:0] S_EMIT_ZERO = 4'd15;

	// if cond: op_t and jump to target, else op_f and step on (or stay on hold)
	typedef struct packed {
		logic [3:0] cond;
		logic [3:0] op_t;
		logic [3:0] target;
		logic [3:0] op_f;
		logic       hold;
	} ucw_t;

	function automatic ucw_t gdoc_ucode(input logic [3:0] pc);
		ucw_t w;
		case (pc)
			S_FETCH:     w = '{C_IN_VALID,   OP_LOAD,      S_CHECK,    OP_NOP,     1'b1};
			S_CHECK:     w = '{C_HEAD_BAD,   OP_NOP,       S_EMIT_ZERO, OP_NOP,    1'b0};
			S_YWALK:     w = '{C_CY_LT_Y,    OP_YEAR_UP,   S_YWALK,    OP_NOP,     1'b0};
			S_DCHK:      w = '{C_DAY_BAD,    OP_NOP,       S_EMIT_ZERO, OP_NOP,    1'b0};
			S_MWALK:     w = '{C_MC_LT_M,    OP_DOY_ADD,   S_MWALK,    OP_DOY_FIN, 1'b0};
			S_SUM:       w = '{C_NEVER,      OP_NOP,       S_FETCH,    OP_SUM,     1'b0};
			S_TOT:       w = '{C_NEVER,      OP_NOP,       S_FETCH,    OP_TOT,     1'b0};
			S_TCHK:      w = '{C_TOT_LT1,    OP_NOP,       S_EMIT_SRC, OP_NOP,     1'b0};
			S_BACK:      w = '{C_TOT_LE_ACC, OP_YEAR_DN,   S_BACK,     OP_NOP,     1'b0};
			S_FWD:       w = '{C_FWD,        OP_YEAR_UP,   S_FWD,      OP_NOP,     1'b0};
			S_LCHK:      w = '{C_CY_GT_LIM,  OP_NOP,       S_EMIT_SRC, OP_REM,     1'b0};
			S_RMWALK:    w = '{C_RES_MSTEP,  OP_RES_SUB,   S_RMWALK,   OP_NOP,     1'b0};
			S_EMIT_RES:  w = '{C_OUT_FREE,   OP_EMIT_RES,  S_FETCH,    OP_NOP,     1'b1};
			S_EMIT_SRC:  w = '{C_OUT_FREE,   OP_EMIT_SRC,  S_FETCH,    OP_NOP,     1'b1};
			S_EMIT_ZERO: w = '{C_OUT_FREE,   OP_EMIT_ZERO, S_FETCH,    OP_NOP,     1'b1};
			default:     w = '{C_ALWAYS,     OP_NOP,       S_FETCH,    OP_NOP,     1'b0};
		endcase
		return w;
	endfunction

	// month lengths, zero for a month code outside 1..12
	function automatic logic [DAY_W-1:0] gdoc_mdays(input logic leap,
			input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
			4'd2:                                        r = leap ? 5'd29 : 5'd28;
			default:                                     r = 5'd0;
		endcase
		return r;
	endfunction

	// reduce a small value modulo 7
	function automatic logic [WD_W-1:0] gdoc_wrap7(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 6'd7) begin
				r = r - 6'd7;
			end
		end
		return r[WD_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/gdoc_req_if.sv */
// ----------------------------------------------------------------------------
// gdoc_req_if
// request channel: source date and day offset
// ----------------------------------------------------------------------------
`default_nettype none

interface gdoc_req_if
	import gdoc_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [DAY_W-1:0]         src_day;
	logic [MONTH_W-1:0]       src_month;
	logic [YEAR_W-1:0]        src_year;
	logic signed [OFF_W-1:0]  day_offset;

	modport source (output valid, output src_day, output src_month, output src_year,
		output day_offset, input ready);
	modport sink (input valid, input src_day, input src_month, input src_year,
		input day_offset, output ready);
endinterface

`default_nettype wire

/* src/gdoc_res_if.sv */
// ----------------------------------------------------------------------------
// gdoc_res_if
// result channel: source date facts and shifted date
// ----------------------------------------------------------------------------
`default_nettype none

interface gdoc_res_if
	import gdoc_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic                  src_valid;
	logic [DOY_W-1:0]      day_of_year;
	logic [WD_W-1:0]       weekday;
	logic [SERIAL_W-1:0]   serial_day;
	logic                  res_valid;
	logic [DAY_W-1:0]      res_day;
	logic [MONTH_W-1:0]    res_month;
	logic [YEAR_W-1:0]     res_year;

	modport source (output valid, output src_valid, output day_of_year, output weekday,
		output serial_day, output res_valid, output res_day, output res_month,
		output res_year, input ready);
	modport sink (input valid, input src_valid, input day_of_year, input weekday,
		input serial_day, input res_valid, input res_day, input res_month,
		input res_year, output ready);
endinterface

`default_nettype wire

/* src/gregorian_date_offset_calculator_top.sv */
// ----------------------------------------------------------------------------
// gregorian_date_offset_calculator_top
// date check, day of year, serial count, weekday and day offset, microcoded
// ----------------------------------------------------------------------------
// Usage:
//   req carries a date (day, month, year) and a signed day offset; rsp returns
//   one result per request: validity of the source, day of year, weekday,
//   serial day (1 Jan 1900 is 1), and the shifted date with its own flag.
//   req.ready is high only while the sequencer waits at its fetch step, so one
//   request is worked on at a time.
//   A short program in a control store steps a plain datapath; the year
//   walks step one year per cycle. The source walk runs from 1900 up to
//   the source year, the result walk over the years between the source
//   year and the shifted year, and each year walk is followed by a walk
//   over the months. A source with a year before 1900, a bad month or a
//   zero day skips the walks and goes from its check step straight to the
//   zero answer; a day past the end of its month is only caught after the
//   source walk.
//   Results sit in an output register: a stalled receiver holds the result,
//   the next request is still taken and runs until it needs that register.
//   Reset (arst_n low) returns the sequencer to fetch and drops rsp.valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_offset_calculator_top
	import gdoc_pkg::*;
#(
	parameter int unsigned YEAR_LIMIT = GDOC_YEAR_LIMIT
) (
	input  wire         clk,
	input  wire         arst_n,
	gdoc_req_if.sink    req,
	gdoc_res_if.source  rsp
);

	localparam logic [YEAR_W-1:0] YEAR_LIM = YEAR_W'(YEAR_LIMIT);

	logic [3:0]              pc_q;
	ucw_t                    uw;
	logic                    cond_hit;
	logic [3:0]              op_sel;

	logic [DAY_W-1:0]        d_q;
	logic [MONTH_W-1:0]      m_q;
	logic [YEAR_W-1:0]       y_q;
	logic signed [OFF_W-1:0] off_q;
	logic [YEAR_W-1:0]       cy_q;
	logic [6:0]              c100_q;
	logic [8:0]              c400_q;
	logic [ACC_W-1:0]        acc_q;
	logic [WD_W-1:0]         w7_q;
	logic [WD_W-1:0]         wd_q;
	logic [MONTH_W-1:0]      mc_q;
	logic [DOY_W-1:0]        doy_q;
	logic [ACC_W-1:0]        ser_q;
	logic signed [TOT_W-1:0] tot_q;

	logic                    out_valid_q;
	logic                    o_src_valid_q;
	logic [DOY_W-1:0]        o_doy_q;
	logic [WD_W-1:0]         o_wd_q;
	logic [SERIAL_W-1:0]     o_serial_q;
	logic                    o_res_valid_q;
	logic [DAY_W-1:0]        o_res_day_q;
	logic [MONTH_W-1:0]      o_res_month_q;
	logic [YEAR_W-1:0]       o_res_year_q;

	logic                    leap_cur;
	logic                    leap_dn;
	logic [YEAR_W-1:0]       cy_dn;
	logic [6:0]              c100_up, c100_dn;
	logic [8:0]              c400_up, c400_dn;
	logic [DOY_W-1:0]        ylen_cur, ylen_dn;
	logic [ACC_W-1:0]        acc_next;
	logic signed [TOT_W-1:0] acc_ext;
	logic signed [TOT_W-1:0] fwd_ext;
	logic [DAY_W-1:0]        mdays_cur;
	logic [DAY_W-1:0]        mdays_src;
	logic signed [TOT_W-1:0] mdays_ext;
	logic                    head_bad;
	logic                    out_free;
	logic [SERIAL_W-1:0]     serial_sat;

	assign uw = gdoc_ucode(pc_q);

	// leap rule from the running residues of the current year
	assign leap_cur = (cy_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
	assign cy_dn    = cy_q - 14'd1;
	assign c100_up  = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
	assign c400_up  = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
	assign c100_dn  = (c100_q == 7'd0) ? 7'd99 : c100_q - 7'd1;
	assign c400_dn  = (c400_q == 9'd0) ? 9'd399 : c400_q - 9'd1;
	assign leap_dn  = (cy_dn[1:0] == 2'd0) && ((c100_dn != 7'd0) || (c400_dn == 9'd0));
	assign ylen_cur = 9'd365 + {8'd0, leap_cur};
	assign ylen_dn  = 9'd365 + {8'd0, leap_dn};

	assign acc_next  = acc_q + {14'd0, ylen_cur};
	assign acc_ext   = {2'b00, acc_q};
	assign fwd_ext   = {2'b00, acc_next};
	assign mdays_cur = gdoc_mdays(leap_cur, mc_q);
	assign mdays_src = gdoc_mdays(leap_cur, m_q);
	assign mdays_ext = {20'd0, mdays_cur};

	assign head_bad = (y_q < BASE_YEAR) || (m_q == 4'd0) || (m_q > 4'd12) || (d_q == 5'd0);
	assign out_free = !out_valid_q || rsp.ready;
	assign serial_sat = (ser_q > {1'b0, SERIAL_MAX}) ? SERIAL_MAX : ser_q[SERIAL_W-1:0];

	always_comb begin
		case (uw.cond)
			C_NEVER:      cond_hit = 1'b0;
			C_ALWAYS:     cond_hit = 1'b1;
			C_IN_VALID:   cond_hit = req.valid;
			C_HEAD_BAD:   cond_hit = head_bad;
			C_CY_LT_Y:    cond_hit = cy_q < y_q;
			C_DAY_BAD:    cond_hit = d_q > mdays_src;
			C_MC_LT_M:    cond_hit = mc_q < m_q;
			C_TOT_LT1:    cond_hit = tot_q[TOT_W-1] || (tot_q == '0);
			C_TOT_LE_ACC: cond_hit = tot_q <= acc_ext;
			C_FWD:        cond_hit = (cy_q <= YEAR_LIM) && (tot_q > fwd_ext);
			C_CY_GT_LIM:  cond_hit = cy_q > YEAR_LIM;
			C_RES_MSTEP:  cond_hit = (mc_q < 4'd12) && (tot_q > mdays_ext);
			C_OUT_FREE:   cond_hit = out_free;
			default:      cond_hit = 1'b0;
		endcase
	end

	assign op_sel = cond_hit ? uw.op_t : uw.op_f;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_FETCH;
		end else if (cond_hit) begin
			pc_q <= uw.target;
		end else if (!uw.hold) begin
			pc_q <= pc_q + 4'd1;
		end
	end

	assign req.ready = (pc_q == S_FETCH);

	// datapath
	always_ff @(posedge clk) begin
		case (op_sel)
			OP_LOAD: begin
				d_q    <= req.src_day;
				m_q    <= req.src_month;
				y_q    <= req.src_year;
				off_q  <= req.day_offset;
				cy_q   <= BASE_YEAR;
				c100_q <= 7'd0;
				c400_q <= BASE_C400;
				acc_q  <= '0;
				w7_q   <= '0;
				mc_q   <= 4'd1;
				doy_q  <= '0;
			end
			OP_YEAR_UP: begin
				cy_q   <= cy_q + 14'd1;
				c100_q <= c100_up;
				c400_q <= c400_up;
				acc_q  <= acc_next;
				w7_q   <= gdoc_wrap7({3'd0, w7_q} + 6'd1 + {5'd0, leap_cur});
			end
			OP_YEAR_DN: begin
				cy_q   <= cy_dn;
				c100_q <= c100_dn;
				c400_q <= c400_dn;
				acc_q  <= acc_q - {14'd0, ylen_dn};
			end
			OP_DOY_ADD: begin
				doy_q <= doy_q + {4'd0, mdays_cur};
				// month lengths are 28..31, so their residue is length - 28
				w7_q  <= gdoc_wrap7({3'd0, w7_q} + ({1'b0, mdays_cur} - 6'd28));
				mc_q  <= mc_q + 4'd1;
			end
			OP_DOY_FIN: begin
				doy_q <= doy_q + {4'd0, d_q};
				wd_q  <= gdoc_wrap7({3'd0, w7_q} + {1'b0, d_q});
			end
			OP_SUM: begin
				ser_q <= acc_q + {14'd0, doy_q};
			end
			OP_TOT: begin
				tot_q <= {2'b00, ser_q} + {{2{off_q[OFF_W-1]}}, off_q};
			end
			OP_REM: begin
				tot_q <= tot_q - acc_ext;
				mc_q  <= 4'd1;
			end
			OP_RES_SUB: begin
				tot_q <= tot_q - mdays_ext;
				mc_q  <= mc_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_sel == OP_EMIT_RES || op_sel == OP_EMIT_SRC
				|| op_sel == OP_EMIT_ZERO) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (op_sel)
			OP_EMIT_RES: begin
				o_src_valid_q <= 1'b1;
				o_doy_q       <= doy_q;
				o_wd_q        <= wd_q;
				o_serial_q    <= serial_sat;
				o_res_valid_q <= 1'b1;
				o_res_day_q   <= tot_q[DAY_W-1:0];
				o_res_month_q <= mc_q;
				o_res_year_q  <= cy_q;
			end
			OP_EMIT_SRC: begin
				o_src_valid_q <= 1'b1;
				o_doy_q       <= doy_q;
				o_wd_q        <= wd_q;
				o_serial_q    <= serial_sat;
				o_res_valid_q <= 1'b0;
				o_res_day_q   <= '0;
				o_res_month_q <= '0;
				o_res_year_q  <= '0;
			end
			OP_EMIT_ZERO: begin
				o_src_valid_q <= 1'b0;
				o_doy_q       <= '0;
				o_wd_q        <= '0;
				o_serial_q    <= '0;
				o_res_valid_q <= 1'b0;
				o_res_day_q   <= '0;
				o_res_month_q <= '0;
				o_res_year_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.src_valid   = o_src_valid_q;
	assign rsp.day_of_year = o_doy_q;
	assign rsp.weekday     = o_wd_q;
	assign rsp.serial_day  = o_serial_q;
	assign rsp.res_valid   = o_res_valid_q;
	assign rsp.res_day     = o_res_day_q;
	assign rsp.res_month   = o_res_month_q;
	assign rsp.res_year    = o_res_year_q;

endmodule

`default_nettype wire

/* src/gdoc_checker.sv */
// ----------------------------------------------------------------------------
// gdoc_checker
// port-level checks on the date offset calculator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gdoc_checker
	import gdoc_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  req_valid,
	input wire                  req_ready,
	input wire                  rsp_valid,
	input wire                  rsp_ready,
	input wire                  src_valid,
	input wire [DOY_W-1:0]      day_of_year,
	input wire [WD_W-1:0]       weekday,
	input wire [SERIAL_W-1:0]   serial_day,
	input wire                  res_valid,
	input wire [DAY_W-1:0]      res_day,
	input wire [MONTH_W-1:0]    res_month,
	input wire [YEAR_W-1:0]     res_year
);

	logic fields_zero;
	logic src_fields_ok;
	logic res_fields_ok;

	assign fields_zero = (day_of_year == 9'd0) && (weekday == 3'd0) && (serial_day == 22'd0)
		&& !res_valid && (res_day == 5'd0) && (res_month == 4'd0) && (res_year == 14'd0);
	assign src_fields_ok = (day_of_year != 9'd0) && (day_of_year <= 9'd366)
		&& (weekday <= 3'd6) && (serial_day != 22'd0);
	assign res_fields_ok = src_valid && (res_month != 4'd0) && (res_month <= 4'd12)
		&& (res_day != 5'd0) && (res_year >= 14'd1900);

	// a stalled result stays offered
	`GDOC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// one request at a time: fetch is left right after a request is taken
	`GDOC_ASSERT_NEXT(a_one_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// a bad source date zeroes every field
	`GDOC_ASSERT_IMP(a_bad_src_zero, clk, arst_n, rsp_valid && !src_valid, fields_zero)

	// a good source gives a real ordinal day, weekday and a nonzero serial day
	`GDOC_ASSERT_IMP(a_src_range, clk, arst_n, rsp_valid && src_valid, src_fields_ok)

	// a shifted date only follows a good source and is a real date
	`GDOC_ASSERT_IMP(a_res_range, clk, arst_n, rsp_valid && res_valid, res_fields_ok)

endmodule

bind gregorian_date_offset_calculator_top gdoc_checker u_gdoc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.src_valid   (rsp.src_valid),
	.day_of_year (rsp.day_of_year),
	.weekday     (rsp.weekday),
	.serial_day  (rsp.serial_day),
	.res_valid   (rsp.res_valid),
	.res_day     (rsp.res_day),
	.res_month   (rsp.res_month),
	.res_year    (rsp.res_year)
);

`default_nettype wire

/* tb/sv/gregorian_date_offset_calculator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_offset_calculator_top_tb
// drives dates and day offsets into the calculator and checks every answer
// against an independent calendar predictor: a directed pass over month, leap
// and range edges, then a random mix of recent dates, far dates and noise,
// with random gaps on both channels, a back-to-back run and a long stall of
// the result channel
// ----------------------------------------------------------------------------

module gregorian_date_offset_calculator_top_tb;
	import gdoc_pkg::*;

	localparam int  STALL_LIMIT    = 150000;
	localparam int  RX_HOLD_CYCLES = 600;
	localparam int  TAIL_CYCLES    = 50;
	localparam int  FIRST_YEAR     = 1900;
	localparam longint COUNT_MAX   = 4194303;

	typedef struct packed {
		logic                src_valid;
		logic [DOY_W-1:0]    day_of_year;
		logic [WD_W-1:0]     weekday;
		logic [SERIAL_W-1:0] serial_day;
		logic                res_valid;
		logic [DAY_W-1:0]    res_day;
		logic [MONTH_W-1:0]  res_month;
		logic [YEAR_W-1:0]   res_year;
	} date_answer_t;

	logic clk;
	logic arst_n = 1'b0;

	gdoc_req_if req_ch ();
	gdoc_res_if rsp_ch ();

	gregorian_date_offset_calculator_top #(
		.YEAR_LIMIT(GDOC_YEAR_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	date_answer_t pending_dates[$];
	int mismatch_count   = 0;
	int requests_sent    = 0;
	int answers_seen     = 0;
	int src_ok_count     = 0;
	int shifted_ok_count = 0;
	bit tx_no_idle       = 1'b0;
	bit rx_no_idle       = 1'b0;
	bit hold_req         = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// calendar predictor
	// ------------------------------------------------------------------------
	function automatic bit is_leap(input longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint days_in_month(input bit leap, input longint m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// days from 1 jan 1900 to 1 jan of year y
	function automatic longint days_to_jan1(input longint y);
		longint a;
		a = y - 1;
		return 365 * (y - FIRST_YEAR) + a / 4 - a / 100 + a / 400 - 460;
	endfunction

	function automatic longint sakamoto_key(input longint m);
		case (m)
			1: return 0;  2: return 3;  3: return 2;  4: return 5;
			5: return 0;  6: return 3;  7: return 5;  8: return 1;
			9: return 4;  10: return 6; 11: return 2; default: return 4;
		endcase
	endfunction

	function automatic date_answer_t shift_date(input longint d, input longint m,
			input longint y, input longint off);
		date_answer_t a;
		longint doy, serial, total, wy, ry, rm;
		bit lp;
		a = '0;
		if (y < FIRST_YEAR || m < 1 || m > 12 || d < 1 || d > days_in_month(is_leap(y), m))
			return a;
		lp = is_leap(y);
		doy = d;
		for (longint k = 1; k < m; k++)
			doy += days_in_month(lp, k);
		serial = days_to_jan1(y) + doy;
		wy = (m < 3) ? y - 1 : y;
		a.src_valid   = 1'b1;
		a.day_of_year = doy[DOY_W-1:0];
		a.weekday     = WD_W'((wy + wy / 4 - wy / 100 + wy / 400 + sakamoto_key(m) + d) % 7);
		a.serial_day  = (serial > COUNT_MAX) ? SERIAL_W'(COUNT_MAX) : serial[SERIAL_W-1:0];
		total = serial + off;
		if (total < 1)
			return a;
		ry = FIRST_YEAR + (total - 1) / 366;
		while (ry <= GDOC_YEAR_LIMIT && total > days_to_jan1(ry + 1))
			ry++;
		if (ry > GDOC_YEAR_LIMIT)
			return a;
		total -= days_to_jan1(ry);
		lp = is_leap(ry);
		rm = 1;
		while (rm < 12 && total > days_in_month(lp, rm)) begin
			total -= days_in_month(lp, rm);
			rm++;
		end
		a.res_valid = 1'b1;
		a.res_day   = total[DAY_W-1:0];
		a.res_month = rm[MONTH_W-1:0];
		a.res_year  = ry[YEAR_W-1:0];
		return a;
	endfunction

	// ------------------------------------------------------------------------
	// shared helpers
	// ------------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic send_request(input int src_d, input int src_m, input int src_y,
			input int day_off);
		logic [DAY_W-1:0]        d_v;
		logic [MONTH_W-1:0]      m_v;
		logic [YEAR_W-1:0]       y_v;
		logic signed [OFF_W-1:0] off_v;
		int idle;
		d_v   = src_d[DAY_W-1:0];
		m_v   = src_m[MONTH_W-1:0];
		y_v   = src_y[YEAR_W-1:0];
		off_v = day_off[OFF_W-1:0];
		@(negedge clk);
		req_ch.valid      <= 1'b1;
		req_ch.src_day    <= d_v;
		req_ch.src_month  <= m_v;
		req_ch.src_year   <= y_v;
		req_ch.day_offset <= off_v;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		pending_dates.push_back(shift_date(d_v, m_v, y_v, longint'(off_v)));
		requests_sent++;
		idle = tx_no_idle ? 0 : pick_gap();
		if (idle > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
	endtask

	// a date that is mostly well formed; off_span of zero means any offset
	task automatic send_wellformed(input int year_span, input int off_span);
		int y, m, d, off;
		y = FIRST_YEAR + $urandom_range(0, year_span);
		m = $urandom_range(1, 12);
		if ($urandom_range(0, 19) == 0)
			d = $urandom_range(1, 31);
		else
			d = $urandom_range(1, days_in_month(is_leap(y), m));
		if (off_span == 0)
			off = $urandom();
		else
			off = $urandom_range(0, 2 * off_span) - off_span;
		send_request(d, m, y, off);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		date_answer_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			answers_seen++;
			if (pending_dates.size() == 0) begin
				report_mismatch("result with no request waiting");
			end else begin
				want = pending_dates.pop_front();
				if (want.src_valid)
					src_ok_count++;
				if (want.res_valid)
					shifted_ok_count++;
				check_field("src_valid", rsp_ch.src_valid, want.src_valid);
				check_field("day_of_year", rsp_ch.day_of_year, want.day_of_year);
				check_field("weekday", rsp_ch.weekday, want.weekday);
				check_field("serial_day", rsp_ch.serial_day, want.serial_day);
				check_field("res_valid", rsp_ch.res_valid, want.res_valid);
				check_field("res_day", rsp_ch.res_day, want.res_day);
				check_field("res_month", rsp_ch.res_month, want.res_month);
				check_field("res_year", rsp_ch.res_year, want.res_year);
			end
		end
	end

	// ------------------------------------------------------------------------
	// result receiver: random gaps or none, or a long counted hold on request
	// ------------------------------------------------------------------------
	initial begin : rx_proc
		int gap_left;
		int hold_left;
		gap_left  = 0;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (rx_no_idle) begin
				rsp_ch.ready <= 1'b1;
			end else if (gap_left > 0) begin
				rsp_ch.ready <= 1'b0;
				gap_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				gap_left = pick_gap();
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: cycles with no handshake on either channel
	// ------------------------------------------------------------------------
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
						idle_cycles, pending_dates.size());
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed_dates();
		send_request(1, 1, 1900, 0);
		send_request(2, 1, 1900, -1);          // lands on the first day of the count
		send_request(1, 1, 1900, -1);          // falls before the base
		send_request(31, 12, 1899, 5);
		send_request(0, 0, 0, 0);
		send_request(31, 15, 9999, 4194303);
		send_request(1, 13, 2000, 0);
		send_request(0, 6, 2000, 10);
		send_request(29, 2, 1900, 0);          // century, not leap
		send_request(29, 2, 2000, 0);          // four hundred rule, leap
		send_request(29, 2, 2001, 0);
		send_request(30, 2, 2000, 0);
		send_request(31, 4, 2001, 0);
		send_request(31, 12, 2000, 1);
		send_request(31, 12, 2001, -365);
		send_request(1, 3, 2000, -1);
		send_request(28, 2, 2023, 1);
		send_request(31, 12, 9999, 0);         // last day inside the year limit
		send_request(31, 12, 9999, 1);         // one past the limit
		send_request(1, 1, 1900, 4194303);
		send_request(1, 1, 1900, -4194304);
		send_request(15, 6, 2024, -45000);
		// source year too far out for the serial field: it saturates
		send_request(31, 12, 16383, -4194304);
	endtask

	task automatic test_random_dates();
		int r;
		for (int i = 0; i < 50; i++) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				send_wellformed(150, 60000);
			else if (r < 87)
				send_wellformed(GDOC_YEAR_LIMIT - FIRST_YEAR, 0);
			else
				send_request($urandom_range(0, 31), $urandom_range(0, 15),
					$urandom_range(0, GDOC_YEAR_LIMIT), $urandom());
		end
	endtask

	task automatic test_back_to_back();
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		for (int i = 0; i < 20; i++)
			send_wellformed(50, 3000);
		wait_for_results();
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_stall();
		hold_req   = 1'b1;
		tx_no_idle = 1'b1;
		for (int i = 0; i < 10; i++) begin
			if (i % 2 == 0)
				send_request($urandom_range(1, 28), 0, 1900 + i, i);
			else
				send_wellformed(3, 400);
		end
		tx_no_idle = 1'b0;
		wait_for_results();
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.src_day    = '0;
		req_ch.src_month  = '0;
		req_ch.src_year   = '0;
		req_ch.day_offset = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed_dates();
		wait_for_results();
		test_random_dates();
		wait_for_results();
		test_back_to_back();
		test_output_stall();
		send_wellformed(100, 20000);
		wait_for_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_dates.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_dates.size()));
		$display("%0d date requests sent, %0d answers checked", requests_sent, answers_seen);
		$display("%0d with a valid source date, %0d with the shifted date in range",
			src_ok_count, shifted_ok_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
